>>> hw/rtl/tte_pkg.sv
package tte_pkg;

  // Trellis geometry
  localparam int unsigned StateBits   = 3;
  localparam int unsigned SystemBits  = 1;
  localparam int unsigned ParityBits  = 1;
  localparam int unsigned StateCount  = 1 << StateBits;
  localparam int unsigned TransDepth  = 1 << (StateBits + SystemBits);
  localparam int unsigned TransIdxW   = StateBits + SystemBits;

  // Tail length register
  localparam int unsigned TailLenW    = 4;
  localparam logic [TailLenW-1:0] TailLenReset = 4'd3;
  localparam logic [TailLenW-1:0] TailCap      = 4'd8;

  // Configuration register map (word addresses)
  localparam logic RegTailLength = 1'b0;

  typedef enum logic [1:0] {
    ActWriteTrans = 2'd0,
    ActWriteTail  = 2'd1,
    ActStart      = 2'd2,
    ActEncode     = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0]            action;
    logic [StateBits-1:0]  table_state;
    logic [SystemBits-1:0] table_branch;
    logic [ParityBits-1:0] table_parity;
    logic [StateBits-1:0]  table_next_state;
    logic [SystemBits-1:0] tail_symbol;
    logic [StateBits-1:0]  start_state;
    logic [SystemBits-1:0] symbol;
    logic                  last_symbol;
    logic                  terminate;
  } item_t;

  typedef struct packed {
    logic [SystemBits-1:0] system_out;
    logic [ParityBits-1:0] parity_out;
    logic [StateBits-1:0]  state_after;
    logic                  is_tail;
    logic                  last;
  } result_t;

  // Classified command handed from front to back
  typedef struct packed {
    action_e               kind;
    logic [StateBits-1:0]  addr_state;
    logic [SystemBits-1:0] branch;
    logic [ParityBits-1:0] parity;
    logic [StateBits-1:0]  next_state;
    logic [SystemBits-1:0] tail_symbol;
    logic [StateBits-1:0]  start_state;
    logic [SystemBits-1:0] symbol;
    logic                  last_symbol;
    logic                  add_tail;
  } cmd_t;

  typedef struct packed {
    logic [ParityBits-1:0] parity;
    logic [StateBits-1:0]  next_state;
  } trans_entry_t;

endpackage

>>> hw/rtl/tte_front.sv
module tte_front import tte_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  output logic  cmd_valid_o,
  output cmd_t  cmd_o,
  input  logic  cmd_pop_i
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push;
  logic       do_pop;
  cmd_t       cmd_new;

  // Classify the incoming word
  always_comb begin
    cmd_new             = '0;
    cmd_new.kind        = action_e'(item_i.action);
    cmd_new.addr_state  = item_i.table_state;
    cmd_new.branch      = item_i.table_branch;
    cmd_new.parity      = item_i.table_parity;
    cmd_new.next_state  = item_i.table_next_state;
    cmd_new.tail_symbol = item_i.tail_symbol;
    cmd_new.start_state = item_i.start_state;
    cmd_new.symbol      = item_i.symbol;
    cmd_new.last_symbol = item_i.last_symbol;
    // terminate counts only on the final data symbol
    cmd_new.add_tail    = item_i.last_symbol & item_i.terminate;
  end

  assign full_o      = (count_q == 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign do_push     = push_i & ~full_o;
  assign do_pop      = cmd_pop_i & cmd_valid_o;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold the queued commands
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_new;
    end
  end

`ifndef SYNTHESIS
  a_count_tracks_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
    else $error("command queue pointers disagree with count");
`endif

endmodule

>>> hw/rtl/tte_back.sv
module tte_back import tte_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  cmd_t                cmd_i,
  output logic                cmd_pop_o,
  input  logic [TailLenW-1:0] tail_len_i,
  input  logic                res_room_i,
  output logic                res_push_o,
  output result_t             res_o
);

  trans_entry_t          trans_mem [TransDepth];
  logic [SystemBits-1:0] tail_mem  [StateCount];

  logic [StateBits-1:0]  cur_state_q, cur_state_d;
  logic [TailLenW-1:0]   tail_left_q, tail_left_d;
  logic                  tail_busy;
  logic [SystemBits-1:0] step_sym;
  trans_entry_t          entry;
  logic [TailLenW-1:0]   steps;
  logic                  do_encode;
  logic                  do_other;
  logic                  do_tail;

  assign tail_busy = (tail_left_q != '0);

  // Look up the transition for this step
  assign step_sym = tail_busy ? tail_mem[cur_state_q] : cmd_i.symbol;
  assign entry    = trans_mem[{cur_state_q, step_sym}];

  // Saturate the tail count
  always_comb begin
    steps = '0;
    if (cmd_i.add_tail) begin
      steps = (tail_len_i > TailCap) ? TailCap : tail_len_i;
    end
  end

  assign do_tail   = tail_busy & res_room_i;
  assign do_encode = ~tail_busy & cmd_valid_i & (cmd_i.kind == ActEncode) & res_room_i;
  assign do_other  = ~tail_busy & cmd_valid_i & (cmd_i.kind != ActEncode);
  assign cmd_pop_o = do_encode | do_other;
  assign res_push_o = do_encode | do_tail;

  // Build the result word
  always_comb begin
    res_o             = '0;
    res_o.system_out  = step_sym;
    res_o.parity_out  = entry.parity;
    res_o.state_after = entry.next_state;
    res_o.is_tail     = tail_busy;
    res_o.last        = tail_busy ? (tail_left_q == 4'd1)
                                  : (cmd_i.last_symbol & (steps == '0));
  end

  // Update state and tail counter
  always_comb begin
    cur_state_d = cur_state_q;
    tail_left_d = tail_left_q;
    if (do_tail) begin
      cur_state_d = entry.next_state;
      tail_left_d = tail_left_q - 4'd1;
    end else if (do_encode) begin
      cur_state_d = entry.next_state;
      tail_left_d = steps;
    end else if (do_other && (cmd_i.kind == ActStart)) begin
      cur_state_d = cmd_i.start_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_state_q <= '0;
      tail_left_q <= '0;
    end else begin
      cur_state_q <= cur_state_d;
      tail_left_q <= tail_left_d;
    end
  end

  // Write the tables
  always_ff @(posedge clk_i) begin
    if (do_other) begin
      case (cmd_i.kind)
        ActWriteTrans: begin
          trans_mem[{cmd_i.addr_state, cmd_i.branch}] <= '{parity:     cmd_i.parity,
                                                           next_state: cmd_i.next_state};
        end
        ActWriteTail: begin
          tail_mem[cmd_i.addr_state] <= cmd_i.tail_symbol;
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_tail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_left_q <= TailCap)
    else $error("tail counter beyond cap");
  a_no_pop_in_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_busy |-> !cmd_pop_o)
    else $error("command taken during tail steps");
  a_tail_ends_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.is_tail && res_o.last) |=> (tail_left_q == '0))
    else $error("tail continues after last word");
`endif

endmodule

>>> hw/rtl/tte_res_fifo.sv
module tte_res_fifo import tte_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    room_o,
  output logic    empty_o,
  input  logic    pop_i,
  output result_t data_o
);

  result_t    slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push;
  logic       do_pop;

  assign room_o  = (count_q != 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i & room_o;
  assign do_pop  = pop_i & ~empty_o;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold the waiting result words
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> room_o)
    else $error("result word pushed into full queue");
`endif

endmodule

>>> hw/rtl/trellis_table_encoder_unit.sv
// Table-driven trellis encoder. Load the transition table (action 0) and the
// tail table (action 1) before encoding; start a frame with action 2, then
// push one data symbol per word with action 3. Every word goes into a
// two-entry command queue, so a new word is taken in each cycle while full is
// low. The back end runs one trellis step per cycle while the result queue
// has room: a data symbol yields one result, and a last symbol with terminate
// is followed by min(tail_length, 8) tail steps, each its own lookup of the
// transition table from the state the previous step left. Results leave
// through a two-entry queue; a data word is registered in the command queue and
// its result in the result queue before showing on the result ports. tail_length
// sits at byte address 0 and may be written only while the block is idle.
module trellis_table_encoder_unit import tte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  item_t       item_i,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output result_t     result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [TailLenW-1:0] tail_length_q, tail_length_d;
  logic                cfg_write;
  logic                cmd_valid;
  cmd_t                cmd;
  logic                cmd_pop;
  logic                res_room;
  logic                res_push;
  result_t             res;

  // Handle the register port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & (paddr[2] == RegTailLength);

  always_comb begin
    tail_length_d = tail_length_q;
    if (cfg_write) begin
      tail_length_d = pwdata[TailLenW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegTailLength) begin
      prdata = {{(32-TailLenW){1'b0}}, tail_length_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_length_q <= TailLenReset;
    end else begin
      tail_length_q <= tail_length_d;
    end
  end

  tte_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (item_i),
    .full_o      (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  tte_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .tail_len_i  (tail_length_q),
    .res_room_i  (res_room),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  tte_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .room_o  (res_room),
    .empty_o (empty),
    .pop_i   (pop),
    .data_o  (result_o)
  );

endmodule
